FILE: design/page_framebuffer_refresh_defines.svh
// Assertion macros shared by the framebuffer refresh design.
`ifndef PAGE_FRAMEBUFFER_REFRESH_DEFINES_SVH
`define PAGE_FRAMEBUFFER_REFRESH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PFR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfr assertion failed");

// Next-cycle implication, disabled during reset.
`define PFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfr assertion failed");

`endif

FILE: design/pfr_pkg.sv
// Package: framebuffer geometry, command codes and transaction types.
`timescale 1ns / 1ps
`default_nettype none
package pfr_pkg;

  localparam int COLUMNS  = 128;
  localparam int PAGES    = 4;
  localparam int ROWS     = 8 * PAGES;
  localparam int PAGE_LEN = COLUMNS + 4;
  localparam int DEPTH    = COLUMNS * PAGES;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int OFF_W    = $clog2(PAGE_LEN);
  localparam int PG_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int XS_W     = 9;
  localparam int YS_W     = 8;
  localparam int RP_W     = YS_W - 3;

  localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  typedef enum logic [2:0] {
    FN_SET_PIXEL   = 3'd0,
    FN_CLR_PIXEL   = 3'd1,
    FN_FILL_RECT   = 3'd2,
    FN_CLR_RECT    = 3'd3,
    FN_CLEAR_ALL   = 3'd4,
    FN_START_FRAME = 3'd5,
    FN_NEXT_BYTE   = 3'd6,
    FN_NOP         = 3'd7
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [6:0]  x;
    logic [4:0]  y;
    logic [7:0]  width;
    logic [5:0]  height;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_done;
  } result_t;

  typedef struct packed {
    logic              nonempty;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
    logic              on;
    logic              last;
  } rect_t;

  typedef struct packed {
    logic              active;
    logic              is_data;
    logic [7:0]        cmd_byte;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } refresh_t;

endpackage
`default_nettype wire

FILE: design/page_framebuffer_refresh.sv
// Top level: 128x32 page-layout framebuffer with display refresh byte stream.
//
// Commands enter on cmd and are accepted at a clock edge where start is high
// and busy is low. Only "next byte" during an active refresh produces a result:
// it appears on result for exactly one cycle with strobe high, in the cycle
// after acceptance. The receiver cannot stall; nothing is held back.
// Pixel set/clear, start refresh and next byte leave busy low, so a new
// command may follow every cycle. A pixel update is a read-modify-write on the
// frame RAM; a read that hits the byte being written is forwarded.
// Fill/clear rectangle holds busy while the walker covers its store bytes
// (clipped width times pages touched); the walker does one byte per cycle.
// Clear all holds busy while zeroing the 512 words, one RAM word per cycle.
// After reset the same clearing pass runs with busy high; the invert
// register can be written at any time through cfg_we and cfg_data, which
// applies to data bytes sent afterwards.
`timescale 1ns / 1ps
`default_nettype none
`include "page_framebuffer_refresh_defines.svh"
module page_framebuffer_refresh
  import pfr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  output logic       busy,
  input  wire cmd_t  cmd,
  output logic       strobe,
  output result_t    result,
  input  wire logic  cfg_we,
  input  wire logic  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RECT  = 3'b010,
    ST_CLEAR = 3'b100
  } state_t;

  state_t state, state_next;

  logic              invert;
  logic [ADDR_W-1:0] clr_addr;
  logic              accept;
  logic              is_pixel, pix_on_screen, is_rect, is_next;

  rect_t    rect;
  refresh_t rf;

  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [7:0]        wr_data, ram_rdata, cur;

  logic              st_write, st_write_next, st_emit, st_emit_next;
  logic [ADDR_W-1:0] st_addr, st_addr_next;
  logic [7:0]        st_mask, st_mask_next, st_byte;
  logic              st_on, st_on_next, st_is_data, st_done;

  logic              fwd_hit;
  logic [7:0]        fwd_data;

  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;

  assign is_pixel      = (cmd.func == FN_SET_PIXEL) || (cmd.func == FN_CLR_PIXEL);
  assign is_rect       = (cmd.func == FN_FILL_RECT) || (cmd.func == FN_CLR_RECT);
  assign is_next       = cmd.func == FN_NEXT_BYTE;
  assign pix_on_screen = (int'(cmd.x) < COLUMNS) && (int'(cmd.y) < ROWS);

  pfr_rect u_rect (
    .clk  (clk),
    .load (accept && is_rect),
    .step (state == ST_RECT),
    .cmd  (cmd),
    .rect (rect)
  );

  pfr_refresh u_refresh (
    .clk     (clk),
    .rst     (rst),
    .restart (accept && (cmd.func == FN_START_FRAME)),
    .advance (accept && is_next && rf.active),
    .rf      (rf)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_rect && rect.nonempty) begin
          state_next = ST_RECT;
        end else if (accept && (cmd.func == FN_CLEAR_ALL)) begin
          state_next = ST_CLEAR;
        end
      end
      ST_RECT: begin
        if (rect.last) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // read side and next stage contents
  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = rect.addr;
    st_write_next = 1'b0;
    st_emit_next  = 1'b0;
    st_addr_next  = rect.addr;
    st_mask_next  = rect.mask;
    st_on_next    = rect.on;
    if (state == ST_RECT) begin
      rd_en         = 1'b1;
      st_write_next = 1'b1;
    end else if (accept && is_pixel && pix_on_screen) begin
      rd_en         = 1'b1;
      rd_addr       = ADDR_W'(int'(cmd.y >> 3) * COLUMNS + int'(cmd.x));
      st_write_next = 1'b1;
      st_addr_next  = rd_addr;
      st_mask_next  = 8'(1) << cmd.y[2:0];
      st_on_next    = cmd.func == FN_SET_PIXEL;
    end else if (accept && is_next && rf.active) begin
      rd_en        = rf.is_data;
      rd_addr      = rf.addr;
      st_emit_next = 1'b1;
    end
  end

  assign cur = fwd_hit ? fwd_data : ram_rdata;

  // write side: clearing pass wins over a pending modify
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = st_addr;
    wr_data = st_on ? (cur | st_mask) : (cur & ~st_mask);
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (st_write) begin
      wr_en = 1'b1;
    end
  end

  pfr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      invert   <= 1'b0;
      st_write <= 1'b0;
      st_emit  <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      state    <= state_next;
      st_write <= st_write_next;
      st_emit  <= st_emit_next;
      fwd_hit  <= rd_en && wr_en && (rd_addr == wr_addr);
      if (cfg_we) begin
        invert <= cfg_data;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end else begin
        clr_addr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data   <= wr_data;
    st_addr    <= st_addr_next;
    st_mask    <= st_mask_next;
    st_on      <= st_on_next;
    st_is_data <= rf.is_data;
    st_byte    <= rf.cmd_byte;
    st_done    <= rf.last;
  end

  assign strobe            = st_emit;
  assign result.out_byte   = st_is_data ? (cur ^ {8{invert}}) : st_byte;
  assign result.is_data    = st_is_data;
  assign result.frame_done = st_done;

  `PFR_ASSERT_NOW(a_stage_excl, clk, rst, st_write, !st_emit)
  `PFR_ASSERT_NOW(a_no_emit_clear, clk, rst, state == ST_CLEAR, !strobe)
  `PFR_ASSERT_NEXT(a_idle_next, clk, rst, accept && is_next && !rf.active, !strobe)
  `PFR_ASSERT_NOW(a_done_stops, clk, rst, strobe && result.frame_done, !rf.active)

endmodule
`default_nettype wire

FILE: design/pfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/pfr_rect.sv
// Rectangle walker: clips the rectangle and steps through its store bytes.
`timescale 1ns / 1ps
`default_nettype none
module pfr_rect
  import pfr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  load,
  input  wire logic  step,
  input  wire cmd_t  cmd,
  output rect_t      rect
);

  logic [XS_W-1:0] xs, x1, r_x0, r_x1, r_col;
  logic [YS_W-1:0] ys, y1, y1m, r_y0, r_y1;
  logic [RP_W-1:0] r_page, r_plast;
  logic            r_on;
  logic            col_last;
  logic [YS_W-1:0] row;

  always_comb begin
    xs = XS_W'(cmd.x) + XS_W'(cmd.width);
    x1 = (xs > XS_W'(COLUMNS)) ? XS_W'(COLUMNS) : xs;
    ys = YS_W'(cmd.y) + YS_W'(cmd.height);
    y1 = (ys > YS_W'(ROWS)) ? YS_W'(ROWS) : ys;
    y1m = y1 - YS_W'(1);
  end

  assign col_last = (r_col + XS_W'(1)) == r_x1;

  always_ff @(posedge clk) begin
    if (load) begin
      r_x0    <= XS_W'(cmd.x);
      r_x1    <= x1;
      r_y0    <= YS_W'(cmd.y);
      r_y1    <= y1;
      r_col   <= XS_W'(cmd.x);
      r_page  <= RP_W'(cmd.y >> 3);
      r_plast <= y1m[YS_W-1:3];
      r_on    <= (cmd.func == FN_FILL_RECT);
    end else if (step) begin
      if (col_last) begin
        r_col  <= r_x0;
        r_page <= r_page + RP_W'(1);
      end else begin
        r_col <= r_col + XS_W'(1);
      end
    end
  end

  always_comb begin
    rect.nonempty = (XS_W'(cmd.x) < x1) && (YS_W'(cmd.y) < y1);
    rect.addr     = ADDR_W'(int'(r_page) * COLUMNS + int'(r_col));
    rect.on       = r_on;
    rect.last     = col_last && (r_page == r_plast);
    rect.mask     = '0;
    for (int b = 0; b < 8; b++) begin
      row = {r_page, 3'(b)};
      rect.mask[b] = (row >= r_y0) && (row < r_y1);
    end
  end

endmodule
`default_nettype wire

FILE: design/pfr_refresh.sv
// Refresh sequencer: page and offset counters, command bytes, data address.
`timescale 1ns / 1ps
`default_nettype none
module pfr_refresh
  import pfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic restart,
  input  wire logic advance,
  output refresh_t  rf
);

  logic             active;
  logic [PG_W-1:0]  page;
  logic [OFF_W-1:0] off;
  logic             off_last;

  assign off_last = off == OFF_W'(PAGE_LEN - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      page   <= '0;
      off    <= '0;
    end else if (restart) begin
      active <= 1'b1;
      page   <= '0;
      off    <= '0;
    end else if (advance) begin
      if (rf.last) begin
        active <= 1'b0;
        page   <= '0;
        off    <= '0;
      end else if (off_last) begin
        page <= page + PG_W'(1);
        off  <= '0;
      end else begin
        off <= off + OFF_W'(1);
      end
    end
  end

  always_comb begin
    rf.active  = active;
    rf.is_data = off >= OFF_W'(4);
    rf.last    = off_last && (page == PG_W'(PAGES - 1));
    rf.addr    = ADDR_W'(int'(page) * COLUMNS + int'(off) - 4);
    case (off)
      OFF_W'(0): rf.cmd_byte = CMD_PAGE_ADDR;
      OFF_W'(1): rf.cmd_byte = 8'(page);
      OFF_W'(2): rf.cmd_byte = CMD_COL_LOW;
      default:   rf.cmd_byte = CMD_COL_HIGH;
    endcase
  end

endmodule
`default_nettype wire
